### rtl/core/rme_pkg.sv
// Shared types, constants and the arctangent table for the rotation-to-Euler block.
`default_nettype none
package rme_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int IN_SHIFT      = 8;
  localparam int VEC_W         = 27;
  localparam int ANG_W         = 24;
  localparam int PIN_W         = 18;
  localparam int IDX_W         = 5;

  localparam logic signed [ANG_W-1:0] PI_INTERNAL = 24'sd3294199;
  localparam logic signed [16:0]      ANGLE_MAX   = 17'sd25736;
  localparam logic [15:0]             INV_GAIN    = 16'd39797;

  typedef struct packed {
    logic signed [15:0] r_00;
    logic signed [15:0] r_10;
    logic signed [15:0] r_20;
    logic signed [15:0] r_21;
    logic signed [15:0] r_22;
    logic signed [15:0] r_12;
    logic signed [15:0] r_11;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               singular_flag;
  } out_word_t;

  typedef struct packed {
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] r_20;
    logic signed [15:0] r_21;
    logic signed [15:0] r_22;
    logic signed [15:0] r_12;
    logic signed [15:0] r_11;
  } side_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic               sing;
  } late_t;

  // atan(2^-i) scaled by 2^20, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 24'sd823550;
      5'd1:  v = 24'sd486170;
      5'd2:  v = 24'sd256879;
      5'd3:  v = 24'sd130396;
      5'd4:  v = 24'sd65451;
      5'd5:  v = 24'sd32757;
      5'd6:  v = 24'sd16383;
      5'd7:  v = 24'sd8192;
      5'd8:  v = 24'sd4096;
      5'd9:  v = 24'sd2048;
      5'd10: v = 24'sd1024;
      5'd11: v = 24'sd512;
      5'd12: v = 24'sd256;
      5'd13: v = 24'sd128;
      5'd14: v = 24'sd64;
      5'd15: v = 24'sd32;
      5'd16: v = 24'sd16;
      5'd17: v = 24'sd8;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rme_cell.sv
// One registered CORDIC vectoring iteration.
`default_nettype none
module rme_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [rme_pkg::IDX_W-1:0]   idx,
  input  wire logic                        vld_i,
  input  wire rme_pkg::vec_t               vec_i,
  output logic                             vld_o,
  output rme_pkg::vec_t                    vec_o
);

  logic                            vld_r;
  rme_pkg::vec_t                   vec_r;
  rme_pkg::vec_t                   vec_nxt;
  logic signed [rme_pkg::VEC_W-1:0] xi, yi, xs, ys;

  always_comb begin
    xi = vec_i.x;
    yi = vec_i.y;
    xs = xi >>> idx;
    ys = yi >>> idx;
    vec_nxt      = vec_i;
    if (yi >= 0) begin
      vec_nxt.x = xi + ys;
      vec_nxt.y = yi - xs;
      vec_nxt.z = vec_i.z + rme_pkg::atan_entry(idx);
    end else begin
      vec_nxt.x = xi - ys;
      vec_nxt.y = yi + xs;
      vec_nxt.z = vec_i.z - rme_pkg::atan_entry(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign vld_o = vld_r;
  assign vec_o = vec_r;

endmodule
`default_nettype wire

### rtl/core/rme_chain.sv
// CORDIC arctangent: quadrant fold register, a row of iteration cells, angle rounding.
`default_nettype none
module rme_chain (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire logic signed [rme_pkg::PIN_W-1:0]  in_y,
  input  wire logic signed [rme_pkg::PIN_W-1:0]  in_x,
  output logic                                   out_vld,
  output logic signed [15:0]                     out_angle,
  output logic signed [rme_pkg::VEC_W-1:0]       out_mag
);

  localparam int N = rme_pkg::CORDIC_STAGES;

  logic          vld_s [0:N];
  rme_pkg::vec_t vec_s [0:N];
  logic          head_vld_r;
  rme_pkg::vec_t head_r;
  rme_pkg::vec_t head_nxt;
  logic signed [rme_pkg::VEC_W-1:0] xw, yw;
  logic signed [rme_pkg::ANG_W-1:0] zr;
  logic signed [16:0]               ang;

  always_comb begin
    xw = rme_pkg::VEC_W'(in_x) <<< rme_pkg::IN_SHIFT;
    yw = rme_pkg::VEC_W'(in_y) <<< rme_pkg::IN_SHIFT;
    head_nxt.zero = (in_x == '0) && (in_y == '0);
    head_nxt.x    = xw;
    head_nxt.y    = yw;
    head_nxt.z    = '0;
    // A vector in the left half plane is turned by pi first.
    if (xw < 0) begin
      head_nxt.x = -xw;
      head_nxt.y = -yw;
      head_nxt.z = (yw >= 0) ? rme_pkg::PI_INTERNAL : -rme_pkg::PI_INTERNAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) head_vld_r <= 1'b0;
    else        head_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

  assign vld_s[0] = head_vld_r;
  assign vec_s[0] = head_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rme_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (rme_pkg::IDX_W'(i)),
      .vld_i (vld_s[i]),
      .vec_i (vec_s[i]),
      .vld_o (vld_s[i+1]),
      .vec_o (vec_s[i+1])
    );
  end

  always_comb begin
    zr  = (vec_s[N].z + rme_pkg::ANG_W'(64)) >>> 7;
    ang = zr[16:0];
    if (vec_s[N].zero)               ang = '0;
    else if (ang > rme_pkg::ANGLE_MAX)  ang = rme_pkg::ANGLE_MAX;
    else if (ang < -rme_pkg::ANGLE_MAX) ang = -rme_pkg::ANGLE_MAX;
  end

  assign out_vld   = vld_s[N];
  assign out_angle = ang[15:0];
  assign out_mag   = vec_s[N].zero ? '0 : vec_s[N].x;

endmodule
`default_nettype wire

### rtl/core/rotation_matrix_to_euler_xyz_top.sv
// Top level: rotation matrix entries in, roll, pitch and yaw out.
// Usage:
//   Drive in_word and raise start; a word is taken at every clock edge where
//   start is high and busy is low. busy is always low, so a new matrix can be
//   given every cycle.
//   Each result appears on out_word for one cycle with out_valid high, in
//   input order. The receiver cannot stall the block and must take each
//   word as it passes.
//   Pipeline: the yaw CORDIC row (fold register plus 16 cells), the sy
//   multiply register, a register for rounding and the threshold compare,
//   the roll and pitch rows side by side, and one output register.
//   Throughput is one word per cycle.
//   cfg_we with cfg_wdata writes the singular threshold; write it only when
//   no word is in flight. Reset (rst_n low, synchronous) clears all valid
//   bits and sets the threshold to 1.
`default_nettype none
module rotation_matrix_to_euler_xyz_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire rme_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output rme_pkg::out_word_t      out_word,
  input  wire logic               cfg_we,
  input  wire logic [14:0]        cfg_wdata
);

  localparam int N = rme_pkg::CORDIC_STAGES;
  localparam int W = rme_pkg::PIN_W;

  logic [14:0]        thr_r;
  logic               acc;
  rme_pkg::side_t     sb_r [0:N];
  logic               yaw_vld;
  logic signed [15:0] yaw_ang;
  logic signed [rme_pkg::VEC_W-1:0] yaw_mag;

  logic               vld_a_r;
  logic [40:0]        prod_r;
  logic signed [15:0] yaw_a_r;
  rme_pkg::side_t     sb_a_r;

  logic [41:0]        sum_a;
  logic [16:0]        sy_nxt;
  logic               vld_b_r;
  logic [16:0]        sy_r;
  logic               sing_r;
  logic signed [15:0] yaw_b_r;
  rme_pkg::side_t     sb_b_r;

  rme_pkg::late_t     dl_r [0:N];
  logic signed [W-1:0] roll_y, roll_x, pitch_y, pitch_x;
  logic               roll_vld, pitch_vld;
  logic signed [15:0] roll_ang, pitch_ang;
  logic               out_valid_r;
  rme_pkg::out_word_t out_word_r;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n)      thr_r <= 15'd1;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  rme_chain u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (acc),
    .in_y      (W'(in_word.r_10)),
    .in_x      (W'(in_word.r_00)),
    .out_vld   (yaw_vld),
    .out_angle (yaw_ang),
    .out_mag   (yaw_mag)
  );

  // Entries for the later passes ride alongside the yaw row.
  always_ff @(posedge clk) begin
    sb_r[0] <= '{r_20: in_word.r_20, r_21: in_word.r_21, r_22: in_word.r_22,
                 r_12: in_word.r_12, r_11: in_word.r_11};
    for (int k = 1; k <= N; k++) sb_r[k] <= sb_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= yaw_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= 41'(yaw_mag[24:0]) * 41'(rme_pkg::INV_GAIN);
    yaw_a_r <= yaw_ang;
    sb_a_r  <= sb_r[N];
  end

  assign sum_a  = 42'(prod_r) + 42'(1 << 23);
  assign sy_nxt = sum_a[40:24];

  always_ff @(posedge clk) begin
    sy_r    <= sy_nxt;
    sing_r  <= sy_nxt < 17'(thr_r);
    yaw_b_r <= (sy_nxt < 17'(thr_r)) ? 16'sd0 : yaw_a_r;
    sb_b_r  <= sb_a_r;
  end

  always_comb begin
    if (sing_r) begin
      roll_y = -W'(sb_b_r.r_12);
      roll_x = W'(sb_b_r.r_11);
    end else begin
      roll_y = W'(sb_b_r.r_21);
      roll_x = W'(sb_b_r.r_22);
    end
    pitch_y = -W'(sb_b_r.r_20);
    pitch_x = $signed({1'b0, sy_r});
  end

  rme_chain u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vld_b_r),
    .in_y      (roll_y),
    .in_x      (roll_x),
    .out_vld   (roll_vld),
    .out_angle (roll_ang),
    .out_mag   ()
  );

  rme_chain u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vld_b_r),
    .in_y      (pitch_y),
    .in_x      (pitch_x),
    .out_vld   (pitch_vld),
    .out_angle (pitch_ang),
    .out_mag   ()
  );

  always_ff @(posedge clk) begin
    dl_r[0] <= '{yaw: yaw_b_r, sing: sing_r};
    for (int k = 1; k <= N; k++) dl_r[k] <= dl_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= roll_vld & pitch_vld;
  end

  always_ff @(posedge clk) begin
    out_word_r <= '{roll_angle: roll_ang, pitch_angle: pitch_ang,
                    yaw_angle: dl_r[N].yaw, singular_flag: dl_r[N].sing};
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

### bench/tb_rotation_matrix_to_euler_xyz_top.sv
// Testbench for the rotation-matrix-to-Euler block with a bit-true predictor.
`default_nettype none
module tb_rotation_matrix_to_euler_xyz_top;

  localparam int ANG_LIMIT = 25736;
  localparam int PI_Q20    = 3294199;
  localparam int INV_K_Q16 = 39797;
  localparam int LATENCY   = 37;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rme_pkg::in_word_t in_word;
  logic out_valid;
  rme_pkg::out_word_t out_word;
  logic cfg_we;
  logic [14:0] cfg_wdata;

  logic [14:0] threshold;
  int fail_count;

  rotation_matrix_to_euler_xyz_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC; returns the angle at 8192 per radian and the final x.
  function automatic longint cordic_angle(longint yi, longint xi, output longint mag);
    longint x, y, z, xs, ys, ang;
    z = 0;
    if (xi == 0 && yi == 0) begin
      mag = 0;
      return 0;
    end
    x = xi * 256;
    y = yi * 256;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q20 : -PI_Q20;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < rme_pkg::CORDIC_STAGES; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += rme_pkg::atan_entry(i[4:0]);
      end else begin
        x -= ys; y += xs; z -= rme_pkg::atan_entry(i[4:0]);
      end
    end
    mag = x;
    ang = floor_shr(z + 64, 7);
    if (ang > ANG_LIMIT) ang = ANG_LIMIT;
    if (ang < -ANG_LIMIT) ang = -ANG_LIMIT;
    return ang;
  endfunction

  function automatic rme_pkg::out_word_t euler_of(rme_pkg::in_word_t m, logic [14:0] thr);
    rme_pkg::out_word_t r;
    longint mag, unused, sy, yaw, roll, pitch;
    logic sing;
    yaw = cordic_angle(m.r_10, m.r_00, mag);
    sy = floor_shr(mag * INV_K_Q16 + (64'sd1 <<< 23), 24);
    sing = sy < longint'(thr);
    if (!sing) roll = cordic_angle(m.r_21, m.r_22, unused);
    else begin
      roll = cordic_angle(-longint'(m.r_12), m.r_11, unused);
      yaw = 0;
    end
    pitch = cordic_angle(-longint'(m.r_20), sy, unused);
    r.roll_angle = roll[15:0];
    r.pitch_angle = pitch[15:0];
    r.yaw_angle = yaw[15:0];
    r.singular_flag = sing;
    return r;
  endfunction

  class angle_scoreboard;
    rme_pkg::out_word_t pending[$];
    function void note_input(rme_pkg::in_word_t m, logic [14:0] thr);
      pending = {pending, euler_of(m, thr)};
    endfunction
    function int check_result(rme_pkg::out_word_t got);
      rme_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        return 1;
      end
      exp_w = pending.pop_front();
      if (exp_w !== got) begin
        $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d sing %0b,",
                 $time, exp_w.roll_angle, exp_w.pitch_angle, exp_w.yaw_angle,
                 exp_w.singular_flag);
        $display("    actual roll %0d pitch %0d yaw %0d sing %0b",
                 got.roll_angle, got.pitch_angle, got.yaw_angle, got.singular_flag);
        return 1;
      end
      return 0;
    endfunction
  endclass

  angle_scoreboard euler_sb;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) fail_count += euler_sb.check_result(out_word);
  end

  // Drives one word; idles at random unless no_gaps is set.
  task automatic send_matrix(rme_pkg::in_word_t m, bit no_gaps);
    while (!no_gaps && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    euler_sb.note_input(m, threshold);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (euler_sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    threshold = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] near(int v, int spread);
    int r;
    r = v + $urandom_range(2 * spread) - spread;
    return r[15:0];
  endfunction

  // Roughly a rotation: build from random angles at Q1.14.
  function automatic rme_pkg::in_word_t rotation_like(bit gimbal);
    rme_pkg::in_word_t m;
    real a, b, c;
    a = real'(int'($urandom_range(62831)) - 31415) / 10000.0;
    b = gimbal ? (($urandom_range(1)) ? 1.5707963 : -1.5707963)
               : real'(int'($urandom_range(31415)) - 15707) / 10000.0;
    c = real'(int'($urandom_range(62831)) - 31415) / 10000.0;
    m.r_00 = $rtoi(16384.0 * $cos(b) * $cos(c));
    m.r_10 = $rtoi(16384.0 * $cos(b) * $sin(c));
    m.r_20 = $rtoi(-16384.0 * $sin(b));
    m.r_21 = $rtoi(16384.0 * $sin(a) * $cos(b));
    m.r_22 = $rtoi(16384.0 * $cos(a) * $cos(b));
    m.r_12 = $rtoi(16384.0 * ($cos(c) * $sin(a) * $sin(b) - $sin(c) * $cos(a)) * 1.0);
    m.r_11 = $rtoi(16384.0 * ($sin(c) * $sin(a) * $sin(b) + $cos(c) * $cos(a)));
    return m;
  endfunction

  function automatic rme_pkg::in_word_t noise_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(rme_pkg::in_word_t)-1:0];
  endfunction

  initial begin
    rme_pkg::in_word_t m;
    logic signed [15:0] ext[6];
    fail_count = 0;
    euler_sb = new();
    threshold = 15'd1;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, axis signs, extremes and the negative-x pi cases.
    ext = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh4000, 16'shc000, 16'sh0001};
    send_matrix('0, 1'b0);
    for (int i = 0; i < 6; i++) begin
      m.r_00 = ext[i]; m.r_10 = ext[(i + 1) % 6]; m.r_20 = ext[(i + 2) % 6];
      m.r_21 = ext[(i + 3) % 6]; m.r_22 = ext[(i + 4) % 6];
      m.r_12 = ext[(i + 5) % 6]; m.r_11 = ext[i];
      send_matrix(m, 1'b0);
    end
    m = '0; m.r_00 = -16'sd16384; m.r_22 = -16'sd16384; m.r_11 = -16'sd16384;
    send_matrix(m, 1'b0);
    m.r_10 = -16'sd1; m.r_21 = -16'sd1; m.r_20 = 16'sd16384;
    send_matrix(m, 1'b0);
    m = '0; m.r_20 = -16'sd16384; m.r_11 = 16'sd16384; m.r_12 = 16'sd100;
    send_matrix(m, 1'b0);
    m = '1;
    send_matrix(m, 1'b0);
    m = {7{16'sh5555}};
    send_matrix(m, 1'b0);
    m = {7{16'shaaaa}};
    send_matrix(m, 1'b0);

    // Random phases across thresholds, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      unique case (ph)
        0: write_threshold(15'd0);
        1: write_threshold(15'd16384);
        2: write_threshold(15'd1);
        3: write_threshold(15'd200);
        4: write_threshold(15'h7fff);
        default: write_threshold(15'($urandom_range(16384)));
      endcase
      for (int n = 0; n < 85; n++) begin
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) m = rotation_like(1'b0);
        else if (pick < 7) m = rotation_like(1'b1);
        else if (pick < 8) begin
          m = rotation_like(1'b0);
          m.r_00 = near(0, 3 * threshold + 4);
          m.r_10 = near(0, 3 * threshold + 4);
        end else m = noise_word();
        send_matrix(m, ph == 2);
        if (ph == 3 && n == 40) drain();
      end
    end

    drain();
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && euler_sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/core/rme_pkg.sv
rtl/core/rme_cell.sv
rtl/core/rme_chain.sv
rtl/core/rotation_matrix_to_euler_xyz_top.sv
bench/tb_rotation_matrix_to_euler_xyz_top.sv
